// File: hdl/array_store_with_threshold_purge_unit_macros.svh
// assertion macros for the array store with threshold purge
`ifndef ARRAY_STORE_WITH_THRESHOLD_PURGE_UNIT_MACROS_SVH
`define ARRAY_STORE_WITH_THRESHOLD_PURGE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/astp_pkg.sv
// shared types and constants of the array store with threshold purge
`default_nettype none
package astp_pkg;

  localparam int KIND_W  = 3;
  localparam int VAL_W   = 20;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int STAT_W  = 2;

  localparam int CAPACITY_DEF   = 4096;
  localparam int VALUE_BITS_DEF = 20;

  localparam logic [VAL_W-1:0] THRESH_RESET = VAL_W'(500000);

  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_INSERT = 3'd1,
    K_REMOVE = 3'd2,
    K_READ   = 3'd3,
    K_PURGE  = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_PURGE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic fetch_done;
    logic purge_step;
    logic purge_finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic start_fetch;
    logic start_purge;
    logic purge_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/astp_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module astp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/astp_ctrl.sv
// controller state machine of the array store with threshold purge
`default_nettype none
module astp_ctrl
  import astp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (stat.start_fetch) begin
            state_next = S_FETCH;
          end else if (stat.start_purge) begin
            state_next = S_PURGE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch_done = 1'b1;
        state_next     = S_DONE;
      end
      S_PURGE: begin
        if (stat.purge_done) begin
          cmd.purge_finish = 1'b1;
          state_next       = S_DONE;
        end else begin
          cmd.purge_step = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/astp_dp.sv
// datapath: ring pointers, value ram, purge walk and result registers
`default_nettype none
`include "array_store_with_threshold_purge_unit_macros.svh"
module astp_dp
  import astp_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic              cfg_wr_en,
  input  wire logic [VAL_W-1:0]  cfg_wr_data,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic [IDX_W-1:0]  index,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [VAL_W-1:0]       read_value,
  output logic [CNT_W-1:0]       removed_count,
  output logic [CNT_W-1:0]       length,
  output logic [STAT_W-1:0]      status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_W = (AW+1)'(CAPACITY);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
  localparam logic [LW-1:0] FULL  = LW'(CAPACITY);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]    head;
  logic [LW-1:0]    len;
  logic [VAL_W-1:0] thresh;
  logic [LW-1:0]    k;
  logic [LW-1:0]    kept;
  logic             pipe_v;

  logic [VAL_W-1:0]  res_rv;
  logic [LW-1:0]     res_removed;
  status_t           res_status;
  status_t           start_status;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [VALUE_BITS-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_rd_data;

  kind_t kd;
  logic  is_full;
  logic  is_empty;
  logic  bad_idx;
  logic  keep;
  logic [AW-1:0] head_dec;

  logic [VALUE_BITS+VAL_W-1:0] val_wide;
  logic [VALUE_BITS+VAL_W-1:0] data_wide;
  logic [VALUE_BITS+VAL_W-1:0] thr_wide;
  logic [LW+IDX_W-1:0]         idx_wide;
  logic [LW+IDX_W-1:0]         len_wide;
  logic [LW+CNT_W-1:0]         len_out_wide;
  logic [LW+CNT_W-1:0]         rem_out_wide;

  assign kd        = kind_t'(kind);
  assign is_full   = (len == FULL);
  assign is_empty  = (len == '0);
  assign val_wide  = {{VALUE_BITS{1'b0}}, value};
  assign data_wide = {{VAL_W{1'b0}}, ram_rd_data};
  assign thr_wide  = {{VALUE_BITS{1'b0}}, thresh};
  assign idx_wide  = {{LW{1'b0}}, index};
  assign len_wide  = {{IDX_W{1'b0}}, len};
  assign bad_idx   = (idx_wide >= len_wide);
  assign keep      = (data_wide <= thr_wide);
  assign head_dec  = (head == '0) ? LAST : head - AW'(1);

  assign stat.start_fetch = ((kd == K_REMOVE) && !is_empty) ||
                            ((kd == K_READ) && !bad_idx);
  assign stat.start_purge = (kd == K_PURGE);
  assign stat.purge_done  = (k == len) && !pipe_v;
  assign stat.out_free    = !out_valid || !out_stall;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot_of(head, len[AW-1:0]);
    ram_wr_data = val_wide[VALUE_BITS-1:0];
    ram_rd_en   = 1'b0;
    ram_rd_addr = head;
    if (cmd.start) begin
      unique case (kd)
        K_APPEND: begin
          ram_wr_en = !is_full;
        end
        K_INSERT: begin
          ram_wr_en   = !is_full;
          ram_wr_addr = head_dec;
        end
        K_REMOVE: begin
          ram_rd_en = !is_empty;
        end
        K_READ: begin
          ram_rd_en   = !bad_idx;
          ram_rd_addr = slot_of(head, idx_wide[AW-1:0]);
        end
        K_PURGE: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.purge_step) begin
      // read the next element while the previous one is written back
      ram_rd_en   = (k != len);
      ram_rd_addr = slot_of(head, k[AW-1:0]);
      ram_wr_en   = pipe_v && keep;
      ram_wr_addr = slot_of(head, kept[AW-1:0]);
      ram_wr_data = ram_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      len    <= '0;
      thresh <= THRESH_RESET;
      k      <= '0;
      kept   <= '0;
      pipe_v <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh <= cfg_wr_data;
      end
      if (cmd.start) begin
        unique case (kd)
          K_APPEND: begin
            if (!is_full) begin
              len <= len + LW'(1);
            end
          end
          K_INSERT: begin
            if (!is_full) begin
              head <= head_dec;
              len  <= len + LW'(1);
            end
          end
          K_REMOVE: begin
            if (!is_empty) begin
              head <= slot_of(head, AW'(1));
              len  <= len - LW'(1);
            end
          end
          K_PURGE: begin
            k      <= '0;
            kept   <= '0;
            pipe_v <= 1'b0;
          end
          K_READ: begin
          end
          default: begin
          end
        endcase
      end
      if (cmd.purge_step) begin
        pipe_v <= (k != len);
        if (k != len) begin
          k <= k + LW'(1);
        end
        if (pipe_v && keep) begin
          kept <= kept + LW'(1);
        end
      end
      if (cmd.purge_finish) begin
        len <= kept;
      end
    end
  end

  // status known at accept time
  always_comb begin
    start_status = ST_OK;
    unique case (kd)
      K_APPEND, K_INSERT: begin
        if (is_full) begin
          start_status = ST_FULL;
        end
      end
      K_REMOVE: begin
        if (is_empty) begin
          start_status = ST_EMPTY;
        end
      end
      K_READ: begin
        if (bad_idx) begin
          start_status = ST_BADIDX;
        end
      end
      K_PURGE: begin
      end
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_rv      <= '0;
      res_removed <= '0;
      res_status  <= start_status;
    end
    if (cmd.fetch_done) begin
      res_rv <= data_wide[VAL_W-1:0];
    end
    if (cmd.purge_finish) begin
      res_removed <= len - kept;
    end
  end

  assign len_out_wide = {{CNT_W{1'b0}}, len};
  assign rem_out_wide = {{CNT_W{1'b0}}, res_removed};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_value    <= res_rv;
      removed_count <= rem_out_wide[CNT_W-1:0];
      length        <= len_out_wide[CNT_W-1:0];
      status        <= res_status;
    end
  end

  astp_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  `ASTP_ASSERT_NOW(a_len_cap, 1'b1, len <= FULL, "stored length above capacity")
  `ASTP_ASSERT_NOW(a_kept_le_k, 1'b1, kept <= k, "purge kept count ahead of read count")
  `ASTP_ASSERT_NOW(a_purge_addr, cmd.purge_step && ram_wr_en && ram_rd_en,
                   ram_wr_addr != ram_rd_addr, "purge write hits slot being read")
  `ASTP_ASSERT_NEXT(a_load_clear, cmd.load_out, out_valid, "loaded result not shown")

endmodule
`default_nettype wire

// File: hdl/array_store_with_threshold_purge_unit.sv
// top level of the array store with threshold purge
`default_nettype none
// Ordered store of up to CAPACITY values kept as a ring in one ram. Each
// transfer in carries one operation (append at end, insert at front, remove
// front, read at index, purge) and gives exactly one transfer out with the
// read value, the removed count, the length after the operation and a status.
// One operation is worked at a time. Append, insert, unused kinds and
// failing operations go straight from accept to the result hand-off,
// remove front and a good read pass through a fetch state (registered ram
// read), and a purge walks the store once through the single ram read
// port, one element a cycle, writing kept values back behind the read
// pointer. The output register lets a finished result wait while the next
// operation is taken. The threshold may be written at any time the block is
// idle.
module array_store_with_threshold_purge_unit
  import astp_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,   // stored values, 2 and up
  parameter int VALUE_BITS = VALUE_BITS_DEF  // stored value width
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration: purge threshold
  input  wire logic              cfg_wr_en,
  input  wire logic [VAL_W-1:0]  cfg_wr_data,
  // operation channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic [IDX_W-1:0]  index,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       read_value,
  output logic [CNT_W-1:0]       removed_count,
  output logic [CNT_W-1:0]       length,
  output logic [STAT_W-1:0]      status
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: accept, ram fetch, purge walk, result hand-off
  astp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // pointers, value ram, threshold and output register
  astp_dp #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .kind         (kind),
    .value        (value),
    .index        (index),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .read_value   (read_value),
    .removed_count(removed_count),
    .length       (length),
    .status       (status)
  );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// testbench for the array store with threshold purge: directed, random and capacity tests
module testbench;
  import astp_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_ITEMS_PER_PHASE = 484;

  // kind codes the block leaves unused, they only echo the length
  localparam logic [KIND_W-1:0] K_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_C = 3'd7;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [VAL_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [VAL_W-1:0]  value = '0;
  logic [IDX_W-1:0]  index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  read_value;
  logic [CNT_W-1:0]  removed_count;
  logic [CNT_W-1:0]  length;
  logic [STAT_W-1:0] status;

  array_store_with_threshold_purge_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .value         (value),
    .index         (index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .removed_count (removed_count),
    .length        (length),
    .status        (status)
  );

  // one result of one operation, as the block should report it
  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] length;
    status_t          status;
  } store_result_t;

  // results predicted for accepted operations, oldest first
  store_result_t pending_results[$];

  // shadow copy of the ring: values, front slot, fill level, threshold
  logic [VAL_W-1:0] shadow_values [CAP];
  logic [IDX_W-1:0] shadow_head = '0;
  int               shadow_len = 0;
  logic [VAL_W-1:0] shadow_threshold = THRESH_RESET;

  // idling odds in percent, changed per phase
  int send_gap_pct = 6;
  int recv_stall_pct = 88;
  int mismatch_count = 0;

  always #5 clk = ~clk;

  // receiver stalls at random, independent of what is on the bus
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic int ring_slot(int offset);
    return (int'(shadow_head) + offset) % CAP;
  endfunction

  // apply one operation to the shadow ring and return the result it must give
  function automatic store_result_t predict_store_op(logic [KIND_W-1:0] op_kind,
                                                     logic [VAL_W-1:0] op_value,
                                                     logic [IDX_W-1:0] op_index);
    store_result_t r;
    int kept;
    logic [VAL_W-1:0] v;
    r.read_value = '0;
    r.removed_count = '0;
    r.status = ST_OK;
    case (op_kind)
      K_APPEND: begin
        if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_values[ring_slot(shadow_len)] = op_value;
          shadow_len++;
        end
      end
      K_INSERT: begin
        if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // front moves back one slot, wrapping below zero
          shadow_head = shadow_head - 1'b1;
          shadow_values[shadow_head] = op_value;
          shadow_len++;
        end
      end
      K_REMOVE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = shadow_values[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_len--;
        end
      end
      K_READ: begin
        if (int'(op_index) >= shadow_len) begin
          r.status = ST_BADIDX;
        end else begin
          r.read_value = shadow_values[ring_slot(int'(op_index))];
        end
      end
      K_PURGE: begin
        // compact in place, keeping order of values at or below threshold
        kept = 0;
        for (int k = 0; k < shadow_len; k++) begin
          v = shadow_values[ring_slot(k)];
          if (v <= shadow_threshold) begin
            shadow_values[ring_slot(kept)] = v;
            kept++;
          end
        end
        r.removed_count = CNT_W'(shadow_len - kept);
        shadow_len = kept;
      end
      default: begin
        // unused kinds leave everything as it is
      end
    endcase
    r.length = CNT_W'(shadow_len);
    return r;
  endfunction

  // result checker, compares every accepted transfer out with the oldest prediction
  always @(posedge clk) begin
    store_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result transfer: rv %0d rc %0d len %0d st %0d",
                   read_value, removed_count, length, status);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value || removed_count !== want.removed_count ||
            length !== want.length || status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("result mismatch: want rv %0d rc %0d len %0d st %0d, got rv %0d rc %0d len %0d st %0d",
                     want.read_value, want.removed_count, want.length, want.status,
                     read_value, removed_count, length, status);
        end
      end
    end
  end

  // present one operation and hold it until the transfer in happens;
  // valid stays high afterwards so a back-to-back item needs no dip
  task automatic send_op(logic [KIND_W-1:0] op_kind, logic [VAL_W-1:0] op_value,
                         logic [IDX_W-1:0] op_index);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op_kind;
    value <= op_value;
    index <= op_index;
    pending_results.push_back(predict_store_op(op_kind, op_value, op_index));
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // stop sending, let every predicted result drain, then a short tail
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // threshold writes happen only with the block idle
  task automatic write_threshold(logic [VAL_W-1:0] thr);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_threshold = thr;
  endtask

  // empty store errors, unused kind, ends of the value range, bad indexes
  task automatic test_empty_and_edges();
    send_op(K_REMOVE, '0, '0);
    send_op(K_READ, '0, '0);
    send_op(K_PURGE, '0, '0);
    send_op(K_SPARE_A, VAL_MAX, IDX_MAX);
    send_op(K_APPEND, '0, '0);
    send_op(K_APPEND, VAL_MAX, '0);
    // insert from head slot zero wraps to the top of the ring
    send_op(K_INSERT, shadow_threshold, '0);
    send_op(K_INSERT, shadow_threshold + 1'b1, '0);
    send_op(K_READ, '0, IDX_W'(0));
    send_op(K_READ, '0, IDX_W'(3));
    send_op(K_READ, '0, IDX_W'(4));
    send_op(K_READ, '0, IDX_MAX);
    // the value equal to the threshold stays, the one above goes
    send_op(K_PURGE, '0, '0);
    send_op(K_REMOVE, '0, '0);
    send_op(K_REMOVE, '0, '0);
    send_op(K_REMOVE, '0, '0);
  endtask

  // purges at the lowest and highest thresholds
  task automatic test_threshold_extremes();
    write_threshold('0);
    send_op(K_APPEND, VAL_W'(1), '0);
    send_op(K_INSERT, '0, '0);
    send_op(K_PURGE, '0, '0);
    write_threshold(VAL_MAX);
    send_op(K_APPEND, VAL_MAX, '0);
    send_op(K_PURGE, '0, '0);
  endtask

  // mixed random traffic; store size swings between growing and shrinking runs
  task automatic test_random_phase(int gap_pct, int stall_pct, int items);
    logic [KIND_W-1:0] k;
    logic [VAL_W-1:0] v;
    logic [IDX_W-1:0] ix;
    int pick, add_pct, rem_pct, near;
    bit growing;
    write_threshold(VAL_W'($urandom_range(1, VAL_MAX - 1)));
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    growing = 1'b0;
    for (int n = 0; n < items; n++) begin
      if (n % 80 == 0) growing = !growing;
      add_pct = growing ? 50 : 15;
      rem_pct = growing ? 15 : 50;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) begin
        k = $urandom_range(0, 1) ? K_APPEND : K_INSERT;
      end else if (pick < add_pct + rem_pct) begin
        k = K_REMOVE;
      end else if (pick < 85) begin
        k = K_READ;
      end else if (pick < 95) begin
        k = K_PURGE;
      end else begin
        case ($urandom_range(0, 2))
          0: k = K_SPARE_A;
          1: k = K_SPARE_B;
          default: k = K_SPARE_C;
        endcase
      end
      // values: full range, hugging the threshold, or the two ends
      case ($urandom_range(0, 3))
        0, 1: v = VAL_W'($urandom_range(0, VAL_MAX));
        2: begin
          near = int'(shadow_threshold) + int'($urandom_range(0, 4)) - 2;
          if (near < 0) near = 0;
          if (near > int'(VAL_MAX)) near = int'(VAL_MAX);
          v = VAL_W'(near);
        end
        default: v = $urandom_range(0, 1) ? VAL_MAX : '0;
      endcase
      // mostly in-range indexes, the rest anywhere
      if (shadow_len > 0 && $urandom_range(0, 2) != 0)
        ix = IDX_W'($urandom_range(0, shadow_len - 1));
      else
        ix = IDX_W'($urandom_range(0, IDX_MAX));
      send_op(k, v, ix);
    end
  endtask

  // fill the ring to capacity, hit the full errors, then purge none and all
  task automatic test_fill_to_capacity();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    while (shadow_len > 0) send_op(K_REMOVE, '0, '0);
    // nonzero values so a zero threshold later clears every entry
    while (shadow_len < CAP) send_op(K_APPEND, VAL_W'($urandom_range(1, VAL_MAX)), '0);
    send_op(K_APPEND, VAL_MAX, '0);
    send_op(K_INSERT, VAL_MAX, '0);
    send_op(K_READ, '0, IDX_MAX);
    send_op(K_READ, '0, '0);
    send_op(K_REMOVE, '0, '0);
    send_op(K_INSERT, VAL_MAX, '0);
    write_threshold(VAL_MAX);
    send_op(K_PURGE, '0, '0);
    write_threshold('0);
    send_op(K_PURGE, '0, '0);
    send_op(K_REMOVE, '0, '0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_edges();
    test_threshold_extremes();
    test_random_phase(6, 88, RANDOM_ITEMS_PER_PHASE);
    test_random_phase(88, 6, RANDOM_ITEMS_PER_PHASE);
    test_random_phase(0, 0, RANDOM_ITEMS_PER_PHASE);
    test_fill_to_capacity();
    quiesce();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
